/* rtl/lrupr_pkg.sv */
// ============================================================================
// LRU page replacement package
// Transaction types and the lookup summary shared by the frame table and the
// top level.
// ============================================================================
package lrupr_pkg;

    // Width of the frames-in-use configuration register.
    localparam int CFG_W = 5;
    // Frames in use after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;
    // Saturation value of the fault count.
    localparam logic [15:0] FAULT_MAX = 16'hFFFF;

    // One page reference.
    typedef struct packed {
        logic [15:0] page;
        logic        last_ref;
    } in_item_t;

    // One reference result.
    typedef struct packed {
        logic        hit;
        logic [3:0]  frame_slot;
        logic        evicted_valid;
        logic [15:0] evicted_page;
        logic [15:0] faults_so_far;
        logic        string_end;
    } out_item_t;

    // Outcome of one table lookup, handed from the frame table to the control.
    typedef struct packed {
        logic        hit;
        logic        fill;
        logic [3:0]  frame_slot;
        logic        evicted_valid;
        logic [15:0] evicted_page;
    } lookup_t;

endpackage

/* rtl/lrupr_table.sv */
// ============================================================================
// LRU frame table
// Holds the page and recency rank of every frame in one wide row of a
// synchronous memory. The row is read into a register when a reference is accepted,
// searched and updated from that register, and written back when the result is
// committed.
// ============================================================================
module lrupr_table #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                               aclk,
    input  logic                               rd_en,
    input  logic                               wr_en,
    input  logic [15:0]                        page,
    input  logic [$clog2(NUM_FRAMES+1)-1:0]    filled_count,
    input  logic [$clog2(NUM_FRAMES+1)-1:0]    n_eff,
    output lrupr_pkg::lookup_t                 lookup
);
    import lrupr_pkg::*;

    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int SW = $clog2(NUM_FRAMES);
    localparam int RW = $clog2(NUM_FRAMES);
    localparam int TABLE_ROWS = 1;

    typedef struct packed {
        logic [15:0]   page;
        logic [RW-1:0] rank;
    } entry_t;

    // Single-row table memory and its registered read data.
    entry_t [NUM_FRAMES-1:0] table_mem [TABLE_ROWS];
    entry_t [NUM_FRAMES-1:0] rd_row_reg;
    entry_t [NUM_FRAMES-1:0] new_row;

    logic [NUM_FRAMES-1:0] valid;
    logic [NUM_FRAMES-1:0] usable;
    logic [NUM_FRAMES-1:0] match;
    logic [NUM_FRAMES-1:0] victim;
    logic [SW-1:0]         hit_idx;
    logic [SW-1:0]         victim_idx;
    logic [SW-1:0]         slot;
    logic [RW-1:0]         old_rank;
    logic                  hit;
    logic                  fill;

    // Read on accept, write back on commit; the two never share a cycle.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_row_reg <= table_mem[0];
        end
        if (wr_en) begin
            table_mem[0] <= new_row;
        end
    end

    // Frames fill in index order, so a frame is valid below the fill count.
    always_comb begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            valid[i]  = CW'(i) < filled_count;
            usable[i] = valid[i] && (CW'(i) < n_eff);
            match[i]  = usable[i] && (rd_row_reg[i].page == page);
        end
    end

    // The lowest matching frame wins if a page is held twice.
    always_comb begin
        hit_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (match[i]) begin
                hit_idx = SW'(i);
            end
        end
    end
    assign hit = |match;

    // The victim is the usable frame that no other usable frame outranks.
    always_comb begin
        for (int i = 0; i < NUM_FRAMES; i++) begin
            victim[i] = usable[i];
            for (int j = 0; j < NUM_FRAMES; j++) begin
                if (usable[j] && (rd_row_reg[j].rank > rd_row_reg[i].rank)) begin
                    victim[i] = 1'b0;
                end
            end
        end
        victim_idx = '0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (victim[i]) begin
                victim_idx = SW'(i);
            end
        end
    end

    // Choose the frame used by this reference and the rank it leaves behind.
    always_comb begin
        fill = !hit && (filled_count < n_eff);
        if (hit) begin
            slot     = hit_idx;
            old_rank = rd_row_reg[hit_idx].rank;
        end else if (fill) begin
            slot     = SW'(filled_count);
            old_rank = '0;
        end else begin
            slot     = victim_idx;
            old_rank = rd_row_reg[victim_idx].rank;
        end
    end

    // On a fill age all other valid frames, else those newer than the touched one.
    always_comb begin
        new_row = rd_row_reg;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            if (valid[i] && (SW'(i) != slot) && (fill || (rd_row_reg[i].rank < old_rank))) begin
                new_row[i].rank = rd_row_reg[i].rank + RW'(1);
            end
        end
        new_row[slot].rank = '0;
        if (!hit) begin
            new_row[slot].page = page;
        end
    end

    // Summary for the control logic.
    always_comb begin
        lookup.hit           = hit;
        lookup.fill          = fill;
        lookup.frame_slot    = 4'(slot);
        lookup.evicted_valid = !hit && !fill;
        lookup.evicted_page  = (!hit && !fill) ? rd_row_reg[victim_idx].page : 16'd0;
    end

`ifndef NO_ASSERTIONS
    // At most one frame can be the eviction victim.
    assert property (@(posedge aclk) wr_en |-> $onehot0(victim))
        else $error("more than one eviction victim");
    // A hit always lands on a frame the search was allowed to use.
    assert property (@(posedge aclk) (wr_en && hit) |-> usable[hit_idx])
        else $error("hit on an unusable frame");
    // An eviction only happens when some usable frame exists.
    assert property (@(posedge aclk) (wr_en && !hit && !fill) |-> $onehot(victim))
        else $error("eviction without a victim");
`endif

endmodule

/* rtl/lru_page_replacement_unit.sv */
// A result is registered when its reference commits from the update state. A new
// reference is taken only after the last one commits, due to the read-modify-write
// of the single frame-table row (read on accept, write back on commit). A waiting
// result stalls only the commit; the next reference is still accepted.
// Reset (aresetn, synchronous, active low) empties the table through the fill count
// and clears the fault count; there is no clearing pass and frames_in_use returns to 3.
// ============================================================================
// LRU page replacement unit
// Fully associative page frame table with least-recently-used replacement,
// one result transaction per page reference.
// ============================================================================
module lru_page_replacement_unit #(
    parameter int NUM_FRAMES = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  lrupr_pkg::in_item_t          s_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output lrupr_pkg::out_item_t         m_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lrupr_pkg::CFG_W-1:0]  cfg_data
);
    import lrupr_pkg::*;

    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam int NW = (CW > CFG_W) ? CW : CFG_W;

    typedef enum logic {ST_IDLE, ST_UPDATE} state_t;

    state_t            state_reg;
    logic [CFG_W-1:0]  frames_in_use_reg;
    logic [CW-1:0]     filled_reg;
    logic [CW-1:0]     filled_next;
    logic [15:0]       fault_reg;
    logic [15:0]       fault_next;
    in_item_t          item_reg;
    logic              m_valid_reg;
    out_item_t         m_data_reg;

    logic [NW-1:0]     n_ext;
    logic [CW-1:0]     n_eff;
    logic              s_accept;
    logic              commit;
    lookup_t           lookup;

    // Clamp the frame count to the range 1 .. NUM_FRAMES.
    always_comb begin
        n_ext = NW'(frames_in_use_reg);
        if (n_ext == '0) begin
            n_eff = CW'(1);
        end else if (n_ext > NW'(NUM_FRAMES)) begin
            n_eff = CW'(NUM_FRAMES);
        end else begin
            n_eff = CW'(n_ext);
        end
    end

    // Handshakes: commit waits only for the output register to be free.
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign commit    = (state_reg == ST_UPDATE) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Next fault and fill counts.
    always_comb begin
        fault_next  = fault_reg;
        filled_next = filled_reg;
        if (!lookup.hit && (fault_reg != FAULT_MAX)) begin
            fault_next = fault_reg + 16'd1;
        end
        if (lookup.fill) begin
            filled_next = filled_reg + CW'(1);
        end
    end

    lrupr_table #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_table (
        .aclk         (aclk),
        .rd_en        (s_accept),
        .wr_en        (commit),
        .page         (item_reg.page),
        .filled_count (filled_reg),
        .n_eff        (n_eff),
        .lookup       (lookup)
    );

    // Control state, counters and the result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            frames_in_use_reg <= CFG_RESET;
            filled_reg        <= '0;
            fault_reg         <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                frames_in_use_reg <= cfg_data;
            end
            // The result register fills on commit and empties on its handshake.
            if (commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        item_reg  <= s_data;
                        state_reg <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (commit) begin
                        m_data_reg.hit             <= lookup.hit;
                        m_data_reg.frame_slot      <= lookup.frame_slot;
                        m_data_reg.evicted_valid   <= lookup.evicted_valid;
                        m_data_reg.evicted_page    <= lookup.evicted_page;
                        m_data_reg.faults_so_far   <= fault_next;
                        m_data_reg.string_end      <= item_reg.last_ref;
                        if (item_reg.last_ref) begin
                            filled_reg <= '0;
                            fault_reg  <= '0;
                        end else begin
                            filled_reg <= filled_next;
                            fault_reg  <= fault_next;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    // A result only appears after a commit from the update state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_UPDATE))
        else $error("result without an update");
    // The fill count never exceeds the number of frames.
    assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= CW'(NUM_FRAMES))
        else $error("fill count overflow");
    // A hit result never reports an eviction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.hit) |->
        (!m_data_reg.evicted_valid && (m_data_reg.evicted_page == 16'd0)))
        else $error("hit with eviction");
    // The end of a string empties the table and clears the fault count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (commit && item_reg.last_ref) |=> ((filled_reg == '0) && (fault_reg == '0)))
        else $error("string end did not clear state");
`endif

endmodule
